FILE: design/aes_pkg.sv
package aes_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] blk_t;

  localparam int NumRounds = 10;

  localparam logic [1:0] RegKeyHigh = 2'd0;
  localparam logic [1:0] RegKeyLow  = 2'd1;

  localparam byte_t [0:255] FwdSub = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam byte_t [0:255] InvSub = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Round constants for key schedule rounds 1..10
  localparam byte_t [1:10] Rcon = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic byte_t xtime(byte_t x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block; byte 0 is the most significant
  function automatic byte_t get_byte(blk_t b, int i);
    return b[127 - 8*i -: 8];
  endfunction

  // One key schedule round: previous round key to next
  function automatic blk_t next_key(blk_t k, byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    begin
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {FwdSub[w3[23:16]] ^ rc, FwdSub[w3[15:8]], FwdSub[w3[7:0]], FwdSub[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
    end
  endfunction

endpackage

FILE: design/aes_round.sv
// One pipeline round. Encrypt: sub, shift, mix (unless last), add key.
// Decrypt: inv shift, inv sub, add key, inv mix (unless last).
module aes_round (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          last,
  input  logic          in_valid,
  input  logic          in_op,
  input  aes_pkg::blk_t in_state,
  input  aes_pkg::blk_t enc_key,
  input  aes_pkg::blk_t dec_key,
  output logic          out_valid,
  output logic          out_op,
  output aes_pkg::blk_t out_state
);
  import aes_pkg::*;

  byte_t s [16];
  byte_t t [16];
  byte_t m [16];
  blk_t  res;
  blk_t  keyed;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (!in_op) begin
          t[r + 4*c] = FwdSub[get_byte(in_state, r + 4*((c + r) & 3))];
        end else begin
          t[r + 4*c] = InvSub[get_byte(in_state, r + 4*((c - r + 4) & 3))];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      s[i] = t[i] ^ (in_op ? get_byte(dec_key, i) : 8'h00);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        byte_t a0, a1, a2, a3, x1, x2, x4, y1, y2, y4, z1, z2, z4, w2, w4;
        a0 = s[4*c + r];
        a1 = s[4*c + ((r + 1) & 3)];
        a2 = s[4*c + ((r + 2) & 3)];
        a3 = s[4*c + ((r + 3) & 3)];
        x2 = xtime(a0); x4 = xtime(x2);
        y2 = xtime(a1); y4 = xtime(y2);
        z2 = xtime(a2); z4 = xtime(z2);
        w2 = xtime(a3); w4 = xtime(w2);
        x1 = a0; y1 = a1; z1 = a2;
        if (!in_op) begin
          m[4*c + r] = x2 ^ y2 ^ y1 ^ z1 ^ a3;
        end else begin
          // 0e,0b,0d,09 multiples
          m[4*c + r] = (xtime(x4) ^ x4 ^ x2) ^ (xtime(y4) ^ y2 ^ y1) ^
                       (xtime(z4) ^ z4 ^ z1) ^ (xtime(w4) ^ a3);
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      res[127 - 8*i -: 8] = last ? s[i] : m[i];
    end
    keyed = in_op ? res : (res ^ enc_key);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_op    <= in_op;
      out_state <= keyed;
    end
  end

endmodule

FILE: design/aes128_block_cipher_top.sv
// AES-128 ECB encrypt/decrypt engine.
// Input channel: in_valid/in_ready with op (0 encrypt, 1 decrypt) and the block
// in block_high/block_low, byte 0 in block_high[63:56].
// Output channel: out_valid/out_ready with out_high/out_low.
// Key: write key_high (index 0) and key_low (index 1) through cfg_we,
// cfg_index and cfg_data while the engine is idle. Round keys are expanded
// by a ten-step sequencer, one schedule round per cycle; it runs after
// every key write and after reset. in_ready stays low during reset, in the
// cycle of a key write and while the expansion that follows it runs.
// Throughput: one item per cycle while the output is taken and no key is
// being written or expanded. From acceptance to out_valid an item passes an
// initial whitening stage and ten round stages, the last driving the output.
// Each round is its own register stage holding a valid bit, op and state.
// When the receiver stalls, the whole pipeline holds; apart from key
// writes and expansion, in_ready is low only while the output is full and not taken,
// so nothing is lost or repeated.
// Reset clears all valid bits and the key to zero, then expands that key.
module aes128_block_cipher_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [63:0] block_high,
  input  logic [63:0] block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high,
  output logic [63:0] out_low,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import aes_pkg::*;

  logic [63:0] key_hi;
  logic [63:0] key_lo;
  blk_t        rkey [11];
  logic [3:0]  kcnt;
  logic        kbusy;

  logic        adv;
  logic        v    [11];
  logic        o    [11];
  blk_t        st   [11];

  logic        white_valid;
  logic        white_op;
  blk_t        white_state;

  // Hold everything while the last stage holds an untaken item
  assign adv      = !v[NumRounds] || out_ready;
  // Block new items until the round keys match the key registers
  assign in_ready = adv && !kbusy && !cfg_we;

  // Key registers and schedule sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      key_hi <= '0;
      key_lo <= '0;
      kcnt   <= 4'd1;
      kbusy  <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_index == RegKeyHigh[0:0]) key_hi <= cfg_data;
      else                              key_lo <= cfg_data;
      kcnt  <= 4'd1;
      kbusy <= 1'b1;
    end else if (kbusy) begin
      kcnt <= kcnt + 4'd1;
      if (kcnt == 4'(NumRounds)) kbusy <= 1'b0;
    end
  end

  // First schedule round reads the key registers directly
  always_ff @(posedge clk) begin
    rkey[0] <= {key_hi, key_lo};
    if (kbusy && !cfg_we && !rst) begin
      for (int r = 1; r <= NumRounds; r++) begin
        if (kcnt == 4'(r)) begin
          rkey[r] <= next_key((r == 1) ? {key_hi, key_lo} : rkey[r-1], Rcon[r]);
        end
      end
    end
  end

  // Whitening stage: add round key 0 (encrypt) or 10 (decrypt)
  always_ff @(posedge clk) begin
    if (rst) begin
      white_valid <= 1'b0;
    end else if (adv) begin
      white_valid <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      white_op    <= op;
      white_state <= {block_high, block_low} ^ (op ? rkey[NumRounds] : rkey[0]);
    end
  end

  assign v[0]  = white_valid;
  assign o[0]  = white_op;
  assign st[0] = white_state;

  // Decrypt uses inverse mix on keys folded in the round: key then mix
  for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
    aes_round u_round (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .last      (g == NumRounds),
      .in_valid  (v[g-1]),
      .in_op     (o[g-1]),
      .in_state  (st[g-1]),
      .enc_key   (rkey[g]),
      .dec_key   (rkey[NumRounds - g]),
      .out_valid (v[g]),
      .out_op    (o[g]),
      .out_state (st[g])
    );
  end

  assign out_valid = v[NumRounds];
  assign out_high  = st[NumRounds][127:64];
  assign out_low   = st[NumRounds][63:0];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
    else $error("output item changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !kbusy && !cfg_we |-> in_ready)
    else $error("pipeline blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v[0])
    else $error("accepted item lost at entry");

endmodule

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  localparam string PassMsg = "aes128_block_cipher_top verification clean";
  localparam int ExpandCycles = 11;
  localparam int PipeLatency = 10;
  localparam int LongStall = 400;

  // AES-128 predictor: key schedule plus forward and inverse cipher.
  class aes_scoreboard;
    logic [63:0] key_hi, key_lo;
    blk_t rkeys[11];
    blk_t pending[$];
    int errors;

    function new();
      key_hi = '0;
      key_lo = '0;
      errors = 0;
      derive_keys();
    endfunction

    function byte_t gf_mul(byte_t a, byte_t b);
      byte_t p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
        if (b[0]) p = p ^ a;
        a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        b = b >> 1;
      end
      return p;
    endfunction

    function void derive_keys();
      byte_t w[176];
      byte_t t[4];
      byte_t f, rc;
      rc = 8'h01;
      for (int i = 0; i < 8; i++) begin
        w[i] = key_hi[63 - 8*i -: 8];
        w[8 + i] = key_lo[63 - 8*i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
        for (int j = 0; j < 4; j++) t[j] = w[4*(i-1) + j];
        if (i % 4 == 0) begin
          f = t[0];
          t[0] = FwdSub[t[1]] ^ rc;
          t[1] = FwdSub[t[2]];
          t[2] = FwdSub[t[3]];
          t[3] = FwdSub[f];
          rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
        end
        for (int j = 0; j < 4; j++) w[4*i + j] = w[4*(i-4) + j] ^ t[j];
      end
      for (int r = 0; r < 11; r++)
        for (int i = 0; i < 16; i++) rkeys[r][127 - 8*i -: 8] = w[16*r + i];
    endfunction

    function void write_key(logic [0:0] idx, logic [63:0] val);
      if (idx == RegKeyHigh[0:0]) key_hi = val;
      else key_lo = val;
      derive_keys();
    endfunction

    function blk_t shift_rows(blk_t s, bit inv);
      blk_t o;
      int src;
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++) begin
          src = inv ? ((c - r + 4) % 4) : ((c + r) % 4);
          o[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*src) -: 8];
        end
      return o;
    endfunction

    function blk_t sub_all(blk_t s, bit inv);
      for (int i = 0; i < 16; i++)
        s[127 - 8*i -: 8] = inv ? InvSub[s[127 - 8*i -: 8]] : FwdSub[s[127 - 8*i -: 8]];
      return s;
    endfunction

    function blk_t mix_cols(blk_t s, bit inv);
      byte_t a[4];
      byte_t m0, m1, m2, m3;
      m0 = inv ? 8'h0e : 8'h02;
      m1 = inv ? 8'h0b : 8'h03;
      m2 = inv ? 8'h0d : 8'h01;
      m3 = inv ? 8'h09 : 8'h01;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) a[r] = s[127 - 8*(4*c + r) -: 8];
        for (int r = 0; r < 4; r++)
          s[127 - 8*(4*c + r) -: 8] = gf_mul(a[r], m0) ^ gf_mul(a[(r+1)%4], m1) ^
                                      gf_mul(a[(r+2)%4], m2) ^ gf_mul(a[(r+3)%4], m3);
      end
      return s;
    endfunction

    function void note_block(bit dec, logic [63:0] hi, logic [63:0] lo);
      blk_t s;
      s = {hi, lo};
      if (!dec) begin
        s = s ^ rkeys[0];
        for (int r = 1; r < 10; r++)
          s = mix_cols(shift_rows(sub_all(s, 0), 0), 0) ^ rkeys[r];
        s = shift_rows(sub_all(s, 0), 0) ^ rkeys[10];
      end else begin
        s = s ^ rkeys[10];
        for (int r = 9; r > 0; r--)
          s = mix_cols(sub_all(shift_rows(s, 1), 1) ^ rkeys[r], 1);
        s = sub_all(shift_rows(s, 1), 1) ^ rkeys[0];
      end
      pending.push_back(s);
    endfunction

    function void check_block(logic [63:0] hi, logic [63:0] lo);
      blk_t exp_blk;
      if (pending.size() == 0) begin
        $display("%0t: unexpected block %h_%h", $time, hi, lo);
        errors++;
        return;
      end
      exp_blk = pending.pop_front();
      if (hi !== exp_blk[127:64]) begin
        $display("%0t: out_high expected %h actual %h", $time, exp_blk[127:64], hi);
        errors++;
      end
      if (lo !== exp_blk[63:0]) begin
        $display("%0t: out_low expected %h actual %h", $time, exp_blk[63:0], lo);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic [63:0] block_high = '0;
  logic [63:0] block_low = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_high, out_low;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_scoreboard sb;
  bit hold_sink = 0;     // long receiver stall requested by the stimulus
  bit sink_gaps = 1;     // random receiver gaps on or off

  aes128_block_cipher_top uut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard time limit: 2000+ items, each with random sender and receiver idle gaps.
  initial begin
    #2_000_000;
    $display("aes128_block_cipher_top verification failed");
    $finish;
  end

  // Receiver: draw a gap per item, then take one item; on request, stall for a long stretch.
  initial begin
    int gap;
    wait (sb != null);
    forever begin
      gap = sink_gaps ? $urandom_range(0, 12) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0 || hold_sink) out_ready <= 1'b0;
      repeat (gap) @(posedge clk);
      if (hold_sink) begin
        repeat (LongStall) @(posedge clk);
        hold_sink = 0;
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_block(out_high, out_low);
    end
  end

  // Offer one item and hold it until accepted; gap cycles come first.
  task automatic send_block(bit dec, logic [63:0] hi, logic [63:0] lo, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= dec;
    block_high <= hi;
    block_low <= lo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_block(dec, hi, lo);
  endtask

  // Wait for the engine to drain, then write one key half and let the schedule rebuild.
  task automatic write_key_reg(logic [0:0] idx, logic [63:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_key(idx, val);
    repeat (ExpandCycles + 1) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    logic [63:0] kh, kl;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (ExpandCycles + 1) @(posedge clk);

    // Directed: all-zero key after reset, field extremes, both directions.
    send_block(0, '0, '0, 0);
    send_block(1, '0, '0, 0);
    send_block(0, '1, '1, 0);
    send_block(1, '1, '1, 1);
    send_block(0, 64'h8000_0000_0000_0000, 64'h1, 0);

    // FIPS-197 appendix C.1 key, encrypt and decrypt.
    write_key_reg(RegKeyHigh[0:0], 64'h0001_0203_0405_0607);
    write_key_reg(RegKeyLow[0:0], 64'h0809_0a0b_0c0d_0e0f);
    send_block(0, 64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 0);
    send_block(1, 64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a, 0);

    // One half changed alone; then all-ones key.
    write_key_reg(RegKeyHigh[0:0], '1);
    send_block(0, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 0);
    write_key_reg(RegKeyLow[0:0], '1);
    send_block(1, '0, '1, 0);
    send_block(0, '1, '0, 0);

    // Random phases, each under a fresh key; the middle phase stalls the receiver.
    for (int ph = 0; ph < 8; ph++) begin
      kh = (ph == 7) ? '0 : rand64();
      kl = (ph == 7) ? '0 : rand64();
      write_key_reg(RegKeyHigh[0:0], kh);
      write_key_reg(RegKeyLow[0:0], kl);
      sink_gaps = (ph % 3 != 1);
      if (ph == 3) hold_sink = 1;
      for (int i = 0; i < 250; i++) begin
        // pause the sender until the pipeline has drained
        if (i == 125) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
        send_block(1'($urandom_range(0, 1)), rand64(), rand64(),
                   (ph % 3 == 2) ? 0 : $urandom_range(0, 12));
      end
    end

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PipeLatency + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display(PassMsg);
    end else begin
      $display("aes128_block_cipher_top verification failed");
    end
    $finish;
  end

endmodule
